// ===== rtl/core/cbe_pkg.sv =====
// Shared types and constants of the cubic Bezier evaluator.
// No dependencies; imported by the core, cbe_mul, cbe_div, cbe_sqrt and the testbench.
`default_nettype none
package cbe_pkg;

    localparam int PT_W    = 32;          // Q16.16 coordinate
    localparam int T_BITS  = 16;          // fraction bits of curve_t
    localparam logic [16:0] T_ONE = 17'd65536;
    localparam int SQ_W    = 65;          // dx^2 + dy^2
    localparam int ROOT_W  = 33;          // floor(sqrt) of SQ_W bits
    localparam int DIV_W   = 33;          // divider numerator / divisor
    localparam int NUM_CFG = 8;

    localparam logic [1:0] CMD_EVAL_T    = 2'd0;
    localparam logic [1:0] CMD_LENGTH    = 2'd1;
    localparam logic [1:0] CMD_EVAL_DIST = 2'd2;

    localparam int CFG_START_X = 0;
    localparam int CFG_START_Y = 1;
    localparam int CFG_END_X   = 6;
    localparam int CFG_END_Y   = 7;

    typedef struct packed {
        logic [1:0]         command;
        logic [16:0]        curve_t;
        logic signed [31:0] distance;
        logic [6:0]         subdivisions;
    } t_req;

    typedef struct packed {
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic [31:0]        length;
    } t_rsp;

    typedef enum logic [3:0] {
        S_IDLE,
        S_KNOT,
        S_KDIV,
        S_EVAL,
        S_SQX,
        S_SQY,
        S_SQSUM,
        S_SQRT,
        S_SEG,
        S_RDIV,
        S_IPX,
        S_IPY,
        S_IPEND,
        S_FINISH
    } t_state;

endpackage
`default_nettype wire

// ===== rtl/core/cbe_stream_if.sv =====
// Valid/ready stream channel with a typed payload.
// Payload types come from cbe_pkg at the point of instantiation.
`default_nettype none
interface cbe_stream_if #(parameter type t_payload = logic);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/cubic_bezier_evaluator_core.sv =====
// Cubic Bezier evaluator: sequencer, control point registers and lerp datapath.
// Depends on cbe_pkg, cbe_stream_if, cbe_mul, cbe_div and cbe_sqrt.
//
// One request is processed at a time; ready is high only while the sequencer
// is idle, and a finished result waits in the output register without blocking
// the next request. Command 0 runs twelve lerps through the shared multiplier
// and six line shifts. Commands 1 and 2 run, for each subdivision, a divider
// pass for the knot parameter, the de Casteljau sequence, multiplier steps for
// the squared deltas and the square root; command 2 adds the ratio division
// and the final lerps once the segment is found. A non-positive distance or
// command 3 goes straight to the finish state.
`default_nettype none
module cubic_bezier_evaluator_core
    import cbe_pkg::*;
#(
    parameter int MAX_SUBDIVISIONS = 64,
    parameter int FRACTION_BITS    = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data,
    cbe_stream_if.sink       i_req,
    cbe_stream_if.source     o_rsp
);
    localparam int N_CAP     = (MAX_SUBDIVISIONS < 127) ? MAX_SUBDIVISIONS : 127;
    localparam int ACC_W     = ROOT_W + $clog2(N_CAP + 1);
    localparam int QW        = (FRACTION_BITS + 1 > T_BITS + 1) ? FRACTION_BITS + 1
                                                                : T_BITS + 1;
    localparam int CW        = $clog2(QW + 1);
    localparam int EVAL_LAST = 17;
    localparam logic signed [64:0] HALF_T = 65'sd1 <<< (T_BITS - 1);
    localparam logic signed [64:0] HALF_F = 65'sd1 <<< (FRACTION_BITS - 1);

    t_state r_state, n_state;

    logic signed [31:0] r_cfg [NUM_CFG];
    logic signed [31:0] r_w   [NUM_CFG];   // de Casteljau line, x/y interleaved
    logic signed [31:0] r_px, r_py, r_la, r_rx, r_ry;
    logic [31:0]        r_rlen;
    logic [1:0]         r_cmd;
    logic signed [31:0] r_dist;
    logic [6:0]         r_n, r_i;
    logic [16:0]        r_kt;
    logic [FRACTION_BITS:0] r_ratio;
    logic [4:0]         r_step;
    logic               r_ph, r_lneg;
    logic [ACC_W-1:0]   r_acc;
    logic [SQ_W-1:0]    r_sq;
    logic [ROOT_W-1:0]  r_len;
    t_rsp               r_out;
    logic               r_ovalid;

    logic [31:0]        mul_a, mul_b;
    logic [63:0]        prod;
    logic               div_start, div_done, sqrt_start, sqrt_done;
    logic [DIV_W-1:0]   div_num, div_den;
    logic [CW-1:0]      div_steps;
    logic [QW-1:0]      div_quot;
    logic [ROOT_W-1:0]  sqrt_root;
    logic [SQ_W-1:0]    sq_sum;

    logic signed [32:0] d0, dxs, dys, delta, lsum;
    logic signed [64:0] sp, sh_t, sh_f;
    logic signed [31:0] lerp_res;
    logic               use_fb, eval_shift, load_out;
    logic [ACC_W-1:0]   acc_new, d_ext, d_rem;
    logic               hit, last_knot;

    logic [16:0]        req_t;
    logic [6:0]         req_n;

    function automatic logic [31:0] mag33(input logic signed [32:0] v);
        logic [32:0] a;
        a = v[32] ? 33'(-v) : v;
        return a[31:0];
    endfunction

    // Shift-only steps drop the stale tail of the line between rounds.
    function automatic logic is_shift(input logic [4:0] s);
        return (s >= 5'd6 && s < 5'd8) || (s >= 5'd12 && s < 5'd16);
    endfunction

    cbe_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (prod)
    );

    cbe_div #(.QW(QW), .CW(CW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .i_steps (div_steps),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    cbe_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sqrt_start),
        .i_rad   (sq_sum),
        .o_done  (sqrt_done),
        .o_root  (sqrt_root)
    );

    // request field conditioning
    always_comb begin
        req_t = (i_req.payload.curve_t > T_ONE) ? T_ONE : i_req.payload.curve_t;
        if (i_req.payload.subdivisions == 7'd0) begin
            req_n = 7'd1;
        end else if (32'(i_req.payload.subdivisions) > N_CAP) begin
            req_n = 7'(N_CAP);
        end else begin
            req_n = i_req.payload.subdivisions;
        end
    end

    // datapath arithmetic
    always_comb begin
        d0  = $signed({r_w[2][31], r_w[2]}) - $signed({r_w[0][31], r_w[0]});
        dxs = $signed({r_w[6][31], r_w[6]}) - $signed({r_px[31], r_px});
        dys = $signed({r_w[7][31], r_w[7]}) - $signed({r_py[31], r_py});

        case (r_state)
            S_SQX:   begin mul_a = mag33(dxs); mul_b = mag33(dxs); end
            S_SQY:   begin mul_a = mag33(dys); mul_b = mag33(dys); end
            S_IPX:   begin mul_a = mag33(dxs); mul_b = 32'(r_ratio); end
            S_IPY:   begin mul_a = mag33(dys); mul_b = 32'(r_ratio); end
            default: begin mul_a = mag33(d0);  mul_b = 32'(r_kt); end
        endcase

        use_fb   = (r_state == S_IPY) || (r_state == S_IPEND);
        sp       = r_lneg ? -$signed({1'b0, prod}) : $signed({1'b0, prod});
        sh_t     = (sp + HALF_T) >>> T_BITS;
        sh_f     = (sp + HALF_F) >>> FRACTION_BITS;
        delta    = use_fb ? sh_f[32:0] : sh_t[32:0];
        lsum     = $signed({r_la[31], r_la}) + delta;
        lerp_res = lsum[31:0];

        sq_sum     = r_sq + {1'b0, prod};
        eval_shift = is_shift(r_step);

        acc_new   = r_acc + ACC_W'(r_len);
        d_ext     = ACC_W'(r_dist[30:0]);
        d_rem     = d_ext - r_acc;
        hit       = (r_acc < d_ext) && (d_ext <= acc_new);
        last_knot = (r_i == r_n);
    end

    // sequencer
    always_comb begin
        n_state    = r_state;
        div_start  = 1'b0;
        sqrt_start = 1'b0;
        div_num    = DIV_W'(r_i);
        div_den    = DIV_W'(r_n);
        div_steps  = CW'(T_BITS + 1);
        load_out   = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    case (i_req.payload.command)
                        CMD_EVAL_T:    n_state = S_EVAL;
                        CMD_LENGTH:    n_state = S_KNOT;
                        CMD_EVAL_DIST: n_state = (i_req.payload.distance <= 0) ? S_FINISH
                                                                               : S_KNOT;
                        default:       n_state = S_FINISH;
                    endcase
                end
            end
            S_KNOT: begin
                div_start = 1'b1;
                n_state   = S_KDIV;
            end
            S_KDIV: begin
                if (div_done) n_state = S_EVAL;
            end
            S_EVAL: begin
                if (r_step == 5'(EVAL_LAST) && r_ph) n_state = S_SQX;
            end
            S_SQX: begin
                n_state = (r_cmd == CMD_EVAL_T) ? S_FINISH : S_SQY;
            end
            S_SQY:   n_state = S_SQSUM;
            S_SQSUM: begin
                sqrt_start = 1'b1;
                n_state    = S_SQRT;
            end
            S_SQRT: begin
                if (sqrt_done) n_state = S_SEG;
            end
            S_SEG: begin
                if (r_cmd == CMD_EVAL_DIST && hit) begin
                    div_start = 1'b1;
                    div_num   = d_rem[DIV_W-1:0];
                    div_den   = DIV_W'(r_len);
                    div_steps = CW'(FRACTION_BITS + 1);
                    n_state   = S_RDIV;
                end else if (last_knot) begin
                    n_state = S_FINISH;
                end else begin
                    n_state = S_KNOT;
                end
            end
            S_RDIV: begin
                if (div_done) n_state = S_IPX;
            end
            S_IPX:   n_state = S_IPY;
            S_IPY:   n_state = S_IPEND;
            S_IPEND: n_state = S_FINISH;
            S_FINISH: begin
                if (!r_ovalid || o_rsp.ready) begin
                    load_out = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_CFG; k++) r_cfg[k] <= '0;
        end else if (i_cfg_we) begin
            r_cfg[i_cfg_index] <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (load_out) begin
            r_ovalid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out.point_x <= r_rx;
            r_out.point_y <= r_ry;
            r_out.length  <= r_rlen;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_cmd  <= i_req.payload.command;
                r_dist <= i_req.payload.distance;
                r_n    <= req_n;
                r_kt   <= req_t;
                r_i    <= 7'd1;
                r_acc  <= '0;
                r_step <= '0;
                r_ph   <= 1'b0;
                r_rlen <= '0;
                r_px   <= r_cfg[CFG_START_X];
                r_py   <= r_cfg[CFG_START_Y];
                for (int k = 0; k < NUM_CFG; k++) r_w[k] <= r_cfg[k];
                if (i_req.payload.command == CMD_EVAL_DIST) begin
                    r_rx <= r_cfg[CFG_START_X];
                    r_ry <= r_cfg[CFG_START_Y];
                end else begin
                    r_rx <= '0;
                    r_ry <= '0;
                end
            end
            S_KNOT: begin
                r_step <= '0;
                r_ph   <= 1'b0;
                for (int k = 0; k < NUM_CFG; k++) r_w[k] <= r_cfg[k];
            end
            S_KDIV: begin
                if (div_done) r_kt <= div_quot[T_BITS:0];
            end
            S_EVAL: begin
                if (eval_shift) begin
                    for (int k = 0; k < NUM_CFG - 1; k++) r_w[k] <= r_w[k+1];
                    r_w[NUM_CFG-1] <= '0;
                    r_step <= r_step + 1'b1;
                end else if (!r_ph) begin
                    r_la   <= r_w[0];
                    r_lneg <= d0[32];
                    r_ph   <= 1'b1;
                end else begin
                    for (int k = 0; k < NUM_CFG - 1; k++) r_w[k] <= r_w[k+1];
                    r_w[NUM_CFG-1] <= lerp_res;
                    r_ph   <= 1'b0;
                    r_step <= r_step + 1'b1;
                end
            end
            S_SQX: begin
                if (r_cmd == CMD_EVAL_T) begin
                    r_rx <= r_w[6];
                    r_ry <= r_w[7];
                end
            end
            S_SQY:  r_sq <= {1'b0, prod};
            S_SQRT: begin
                if (sqrt_done) r_len <= sqrt_root;
            end
            S_SEG: begin
                r_acc <= acc_new;
                if (!(r_cmd == CMD_EVAL_DIST && hit)) begin
                    if (last_knot) begin
                        r_rx <= r_cfg[CFG_END_X];
                        r_ry <= r_cfg[CFG_END_Y];
                        if (r_cmd == CMD_LENGTH) begin
                            r_rlen <= (|acc_new[ACC_W-1:32]) ? 32'hFFFF_FFFF
                                                             : acc_new[31:0];
                        end
                    end else begin
                        r_px <= r_w[6];
                        r_py <= r_w[7];
                        r_i  <= r_i + 1'b1;
                    end
                end
            end
            S_RDIV: begin
                if (div_done) r_ratio <= div_quot[FRACTION_BITS:0];
            end
            S_IPX: begin
                r_la   <= r_px;
                r_lneg <= dxs[32];
            end
            S_IPY: begin
                r_rx   <= lerp_res;
                r_la   <= r_py;
                r_lneg <= dys[32];
            end
            S_IPEND: r_ry <= lerp_res;
            default: ;
        endcase
    end

    assign i_req.ready   = (r_state == S_IDLE);
    assign o_rsp.valid   = r_ovalid;
    assign o_rsp.payload = r_out;
endmodule
`default_nettype wire

// ===== rtl/core/cbe_mul.sv =====
// Shared 32x32 unsigned multiplier with registered product.
// Depends on cbe_pkg for the operand width.
`default_nettype none
module cbe_mul
    import cbe_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic [PT_W-1:0]     i_a,
    input  wire logic [PT_W-1:0]     i_b,
    output logic      [2*PT_W-1:0]   o_p
);
    logic [2*PT_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;
endmodule
`default_nettype wire

// ===== rtl/core/cbe_div.sv =====
// Iterative restoring divider, one quotient bit per cycle.
// Requires numerator <= divisor; depends on cbe_pkg.
`default_nettype none
module cbe_div
    import cbe_pkg::*;
#(
    parameter int QW = 17,
    parameter int CW = 5
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [DIV_W-1:0]  i_num,
    input  wire logic [DIV_W-1:0]  i_den,
    input  wire logic [CW-1:0]     i_steps,
    output logic                   o_done,
    output logic      [QW-1:0]     o_quot
);
    logic             r_busy, r_done, r_first;
    logic [CW-1:0]    r_cnt;
    logic [DIV_W:0]   r_rem;
    logic [DIV_W-1:0] r_den;
    logic [QW-1:0]    r_q;
    logic [DIV_W:0]   trial, n_rem;
    logic             ge;

    always_comb begin
        trial = r_first ? r_rem : {r_rem[DIV_W-1:0], 1'b0};
        ge    = trial >= {1'b0, r_den};
        n_rem = ge ? trial - {1'b0, r_den} : trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_first <= 1'b1;
            r_rem   <= {1'b0, i_num};
            r_den   <= i_den;
            r_q     <= '0;
            r_cnt   <= i_steps - 1'b1;
        end else if (r_busy) begin
            r_first <= 1'b0;
            r_rem   <= n_rem;
            r_q     <= {r_q[QW-2:0], ge};
            r_cnt   <= r_cnt - 1'b1;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
endmodule
`default_nettype wire

// ===== rtl/core/cbe_sqrt.sv =====
// Iterative integer square root, one root bit per cycle (floor result).
// Depends on cbe_pkg for radicand and root widths.
`default_nettype none
module cbe_sqrt
    import cbe_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [SQ_W-1:0]   i_rad,
    output logic                   o_done,
    output logic      [ROOT_W-1:0] o_root
);
    localparam int RAD_W = 2 * ROOT_W;
    localparam int REM_W = ROOT_W + 2;
    localparam int CNT_W = $clog2(ROOT_W);

    logic              r_busy, r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [RAD_W-1:0]  r_rad;
    logic [REM_W-1:0]  r_rem;
    logic [ROOT_W-1:0] r_root;
    logic [REM_W+1:0]  rem2, trial, diff;
    logic              ge;

    always_comb begin
        rem2  = {r_rem, r_rad[RAD_W-1 -: 2]};
        trial = {2'b00, r_root, 2'b01};
        ge    = rem2 >= trial;
        diff  = rem2 - trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= RAD_W'(i_rad);
            r_rem  <= '0;
            r_root <= '0;
            r_cnt  <= CNT_W'(ROOT_W - 1);
        end else if (r_busy) begin
            r_rad  <= {r_rad[RAD_W-3:0], 2'b00};
            r_rem  <= ge ? diff[REM_W-1:0] : rem2[REM_W-1:0];
            r_root <= {r_root[ROOT_W-2:0], ge};
            r_cnt  <= r_cnt - 1'b1;
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;
endmodule
`default_nettype wire

// ===== sim/tb_cubic_bezier_evaluator_core.sv =====
// Self-checking testbench for cubic_bezier_evaluator_core: evaluate at t, polyline
// length and evaluate at distance, checked against an in-bench fixed point predictor.
// Depends on cbe_pkg, cbe_stream_if and the RTL of the core.
module tb_cubic_bezier_evaluator_core;
    import cbe_pkg::*;

    localparam int MAX_SUB   = 64;
    localparam int FRAC      = 16;
    localparam int CYCLE_CAP = 8000000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;

    cbe_stream_if #(.t_payload(t_req)) req_ch ();
    cbe_stream_if #(.t_payload(t_rsp)) rsp_ch ();

    cubic_bezier_evaluator_core #(
        .MAX_SUBDIVISIONS(MAX_SUB),
        .FRACTION_BITS(FRAC)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data),
        .i_req(req_ch.sink),
        .o_rsp(rsp_ch.source)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // control points as the block holds them, index order of the register map
    logic signed [31:0] ctrl_pt [NUM_CFG];
    t_req pending_reqs [$];
    t_rsp expected_rsps [$];
    int   mismatches = 0;
    int   rsp_count = 0;
    int   req_count = 0;
    int   cmd_seen [4];
    int   max_gap = 3;
    logic [15:0] stall_mask = 16'hFFFF;
    longint cycles = 0;

    // ---------------- predictor ----------------
    function automatic longint lerp_q(longint a, longint b, longint w, int n);
        longint v;
        v = (b - a) * w + (longint'(1) <<< (n - 1));
        return a + (v >>> n);
    endfunction

    function automatic void point_at(input longint t, output longint x, output longint y);
        longint px [4];
        longint py [4];
        for (int i = 0; i < 4; i++) begin
            px[i] = ctrl_pt[2 * i];
            py[i] = ctrl_pt[2 * i + 1];
        end
        for (int r = 1; r < 4; r++) begin
            for (int i = 0; i < 4 - r; i++) begin
                px[i] = lerp_q(px[i], px[i + 1], t, T_BITS);
                py[i] = lerp_q(py[i], py[i + 1], t, T_BITS);
            end
        end
        x = px[0];
        y = py[0];
    endfunction

    function automatic longint unsigned chord_len(longint x0, longint y0,
                                                  longint x1, longint y1);
        logic [127:0] dx, dy, sq, cand;
        logic [63:0]  root;
        dx   = (x1 >= x0) ? 128'(x1 - x0) : 128'(x0 - x1);
        dy   = (y1 >= y0) ? 128'(y1 - y0) : 128'(y0 - y1);
        sq   = dx * dx + dy * dy;
        root = '0;
        for (int b = 33; b >= 0; b--) begin
            cand = 128'(root | (64'd1 << b));
            if (cand * cand <= sq)
                root = cand[63:0];
        end
        return root;
    endfunction

    function automatic int clamp_steps(logic [6:0] n);
        if (n == 0)
            return 1;
        if (n > MAX_SUB)
            return MAX_SUB;
        return n;
    endfunction

    // summed chord length over the first k of n steps
    function automatic longint unsigned knot_dist(int n, int k);
        longint px, py, cx, cy;
        longint unsigned acc;
        acc = 0;
        px  = ctrl_pt[CFG_START_X];
        py  = ctrl_pt[CFG_START_Y];
        for (int i = 1; i <= k; i++) begin
            point_at((longint'(i) * 65536) / n, cx, cy);
            acc += chord_len(px, py, cx, cy);
            px = cx;
            py = cy;
        end
        return acc;
    endfunction

    function automatic t_rsp predict_response(t_req r);
        t_rsp res;
        longint x, y, px, py, cx, cy, d, t;
        longint unsigned acc, prior_len, seg, ratio, total;
        int n;
        n = clamp_steps(r.subdivisions);
        x = 0;
        y = 0;
        total = 0;
        case (r.command)
            CMD_EVAL_T: begin
                t = (r.curve_t > T_ONE) ? longint'(T_ONE) : longint'(r.curve_t);
                point_at(t, x, y);
            end
            CMD_LENGTH: begin
                total = knot_dist(n, n);
                x = ctrl_pt[CFG_END_X];
                y = ctrl_pt[CFG_END_Y];
            end
            CMD_EVAL_DIST: begin
                d  = r.distance;
                px = ctrl_pt[CFG_START_X];
                py = ctrl_pt[CFG_START_Y];
                x  = ctrl_pt[CFG_END_X];
                y  = ctrl_pt[CFG_END_Y];
                acc = 0;
                if (d <= 0) begin
                    x = px;
                    y = py;
                end else begin
                    for (int i = 1; i <= n; i++) begin
                        point_at((longint'(i) * 65536) / n, cx, cy);
                        seg = chord_len(px, py, cx, cy);
                        prior_len = acc;
                        acc += seg;
                        if (prior_len < d && d <= acc) begin
                            ratio = ((d - prior_len) << FRAC) / seg;
                            x = lerp_q(px, cx, ratio, FRAC);
                            y = lerp_q(py, cy, ratio, FRAC);
                            break;
                        end
                        px = cx;
                        py = cy;
                    end
                end
            end
            default: ;
        endcase
        res.point_x = x[31:0];
        res.point_y = y[31:0];
        res.length  = (total > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : total[31:0];
        return res;
    endfunction

    // ---------------- driver ----------------
    int burst_left = 0;
    int gap_left = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_ch.valid   <= 1'b0;
            req_ch.payload <= '0;
        end else if (!(req_ch.valid && !req_ch.ready)) begin
            if (req_ch.valid) begin
                expected_rsps.push_back(predict_response(req_ch.payload));
                cmd_seen[req_ch.payload.command]++;
                req_count++;
            end
            if (gap_left > 0) begin
                req_ch.valid <= 1'b0;
                gap_left--;
            end else if (pending_reqs.size() != 0) begin
                req_ch.payload <= pending_reqs.pop_front();
                req_ch.valid   <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(1, 6);
                    gap_left   = (max_gap == 0) ? 0 : $urandom_range(0, max_gap);
                end else begin
                    burst_left--;
                end
            end else begin
                req_ch.valid <= 1'b0;
            end
        end
    end

    // ---------------- monitor ----------------
    always @(posedge i_clk) begin
        t_rsp want;
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
        end else begin
            rsp_ch.ready <= stall_mask[cycles % 16];
            if (rsp_ch.valid && rsp_ch.ready) begin
                rsp_count++;
                if (expected_rsps.size() == 0) begin
                    if (mismatches < 10)
                        $display("ERROR: unexpected response x=%h y=%h len=%h",
                                 rsp_ch.payload.point_x, rsp_ch.payload.point_y,
                                 rsp_ch.payload.length);
                    mismatches++;
                end else begin
                    want = expected_rsps.pop_front();
                    if (want.point_x !== rsp_ch.payload.point_x
                        || want.point_y !== rsp_ch.payload.point_y
                        || want.length !== rsp_ch.payload.length) begin
                        if (mismatches < 10)
                            $display("ERROR: rsp %0d exp x=%h y=%h len=%h got x=%h y=%h len=%h",
                                     rsp_count, want.point_x, want.point_y, want.length,
                                     rsp_ch.payload.point_x, rsp_ch.payload.point_y,
                                     rsp_ch.payload.length);
                        mismatches++;
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("timeout with %0d responses outstanding", expected_rsps.size());
            $display("FAILURE");
            $finish;
        end
    end

    // ---------------- stimulus ----------------
    task automatic write_points(input logic [31:0] v [NUM_CFG]);
        for (int i = 0; i < NUM_CFG; i++) begin
            @(posedge i_clk);
            i_cfg_we    <= 1'b1;
            i_cfg_index <= 3'(i);
            i_cfg_data  <= v[i];
            ctrl_pt[i]   = v[i];
        end
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic add_req(logic [1:0] cmd, logic [16:0] t, logic [31:0] d, logic [6:0] n);
        t_req r;
        r.command      = cmd;
        r.curve_t      = t;
        r.distance     = d;
        r.subdivisions = n;
        pending_reqs.push_back(r);
    endtask

    task automatic add_random(int count);
        logic [1:0]  cmd;
        logic [16:0] t;
        logic [31:0] d;
        logic [6:0]  n;
        longint unsigned total;
        int sel;
        for (int k = 0; k < count; k++) begin
            sel = $urandom_range(0, 99);
            cmd = (sel < 30) ? CMD_EVAL_T : (sel < 55) ? CMD_LENGTH
                : (sel < 96) ? CMD_EVAL_DIST : 2'd3;
            t = ($urandom_range(0, 9) == 0) ? 17'($urandom_range(65537, 131071))
                                             : 17'($urandom_range(0, 65536));
            sel = $urandom_range(0, 99);
            if (sel < 80)
                n = 7'($urandom_range(1, 8));
            else if (sel < 88)
                n = 7'($urandom_range(9, 63));
            else if (sel < 91)
                n = 7'(MAX_SUB);
            else if (sel < 94)
                n = 7'd0;
            else
                n = 7'($urandom_range(65, 127));
            d = $urandom;
            if (cmd == CMD_EVAL_DIST) begin
                total = knot_dist(clamp_steps(n), clamp_steps(n));
                if (total > 64'h7FFF_FFFF)
                    total = 64'h7FFF_FFFF;
                sel = $urandom_range(0, 99);
                if (sel < 50 && total > 0)
                    d = 32'($urandom_range(1, 32'(total)));
                else if (sel < 65)
                    d = 32'(knot_dist(clamp_steps(n), $urandom_range(1, clamp_steps(n))));
                else if (sel < 75 && total < 64'h7FFF_FF00)
                    d = 32'(total + $urandom_range(0, 255));
                else if (sel < 85)
                    d = -32'($urandom_range(0, 1000));
            end
            add_req(cmd, t, d, n);
        end
    endtask

    task automatic drain();
        while (pending_reqs.size() != 0 || req_ch.valid || expected_rsps.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    initial begin
        logic [31:0] pts [NUM_CFG];
        req_ch.valid   = 1'b0;
        req_ch.payload = '0;
        rsp_ch.ready   = 1'b0;
        for (int i = 0; i < NUM_CFG; i++)
            ctrl_pt[i] = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // all points at the origin after reset
        add_req(CMD_EVAL_T, 17'd40000, 32'd0, 7'd2);
        add_req(CMD_LENGTH, 17'd0, 32'd0, 7'd5);
        add_req(CMD_EVAL_DIST, 17'd0, 32'd100, 7'd3);
        drain();

        // directed on a small arch, no idling on either side
        max_gap    = 0;
        stall_mask = 16'hFFFF;
        pts = '{32'(0), 32'(0), 32'(10 << 16), 32'(20 << 16),
                32'(30 << 16), 32'(20 << 16), 32'(40 << 16), 32'(0)};
        write_points(pts);
        add_req(CMD_EVAL_T, 17'd0, 32'd0, 7'd1);
        add_req(CMD_EVAL_T, T_ONE, 32'd0, 7'd1);
        add_req(CMD_EVAL_T, 17'd32768, 32'd0, 7'd1);
        add_req(CMD_EVAL_T, 17'h1FFFF, 32'hFFFF_FFFF, 7'h7F);    // t above one
        add_req(CMD_EVAL_T, 17'd1, 32'd0, 7'd1);
        add_req(CMD_LENGTH, 17'd0, 32'd0, 7'd1);
        add_req(CMD_LENGTH, 17'd0, 32'd0, 7'd0);                  // zero steps
        add_req(CMD_LENGTH, 17'd0, 32'd0, 7'(MAX_SUB));
        add_req(CMD_LENGTH, 17'd0, 32'd0, 7'h7F);                 // clamped steps
        add_req(CMD_EVAL_DIST, 17'd0, 32'd0, 7'd4);
        add_req(CMD_EVAL_DIST, 17'd0, 32'hFFFF_FFFF, 7'd4);
        add_req(CMD_EVAL_DIST, 17'd0, 32'h8000_0000, 7'd4);
        add_req(CMD_EVAL_DIST, 17'd0, 32'h7FFF_FFFF, 7'd4);
        add_req(CMD_EVAL_DIST, 17'd0, 32'(knot_dist(4, 2)), 7'd4); // exactly on a knot
        add_req(CMD_EVAL_DIST, 17'd0, 32'(knot_dist(4, 4)), 7'd4);
        add_req(CMD_EVAL_DIST, 17'd0, 32'(knot_dist(4, 4) + 1), 7'd4);
        add_req(CMD_EVAL_DIST, 17'd0, 32'd1, 7'd4);
        add_req(CMD_EVAL_DIST, 17'd0, 32'(knot_dist(3, 3) / 2), 7'd3);
        add_req(2'd3, 17'h1FFFF, 32'hFFFF_FFFF, 7'h7F);
        drain();

        max_gap    = 3;
        stall_mask = 16'($urandom) | 16'h0101;
        add_random(50);
        drain();

        // extreme corners, lengths saturate
        pts = '{32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
        write_points(pts);
        stall_mask = 16'h5A5F;
        add_random(35);
        drain();

        // full range random points
        for (int i = 0; i < NUM_CFG; i++)
            pts[i] = $urandom;
        write_points(pts);
        max_gap    = 6;
        stall_mask = 16'($urandom) | 16'h0001;
        add_random(40);
        drain();

        // moderate random points
        for (int i = 0; i < NUM_CFG; i++)
            pts[i] = 32'($signed($urandom_range(0, 32'h01FF_FFFF)) - 32'sh0100_0000);
        write_points(pts);
        max_gap    = 2;
        stall_mask = 16'hFFFF;
        add_random(50);
        drain();

        // degenerate curve: every segment has zero length
        for (int i = 0; i < NUM_CFG; i++)
            pts[i] = (i % 2 == 0) ? 32'h0003_8000 : 32'hFFF0_0000;
        write_points(pts);
        stall_mask = 16'h3333;
        add_random(25);
        drain();

        repeat (20) @(posedge i_clk);
        $display("Covered %0d requests (eval_t %0d, length %0d, eval_dist %0d, other %0d)",
                 req_count, cmd_seen[0], cmd_seen[1], cmd_seen[2], cmd_seen[3]);
        $display("over six control point settings; %0d responses, %0d mismatches",
                 rsp_count, mismatches);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule

// ===== files.f =====
rtl/core/cbe_pkg.sv
rtl/core/cbe_stream_if.sv
rtl/core/cbe_mul.sv
rtl/core/cbe_div.sv
rtl/core/cbe_sqrt.sv
rtl/core/cubic_bezier_evaluator_core.sv
sim/tb_cubic_bezier_evaluator_core.sv
